[src/utt_pkg.sv]
package utt_pkg;

	// end-of-stream status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_ILLEGAL   = 2'd2;

	// result kinds
	localparam logic KIND_UNIT   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam int unsigned MaxResults = 3;

	localparam logic [20:0] SuppBase  = 21'h010000;
	localparam logic [20:0] CodeMax   = 21'h10FFFF;
	localparam logic [15:0] HiSurBase = 16'hD800;
	localparam logic [15:0] LoSurBase = 16'hDC00;
	localparam logic [15:0] SurLast   = 16'hDFFF;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        kind;
		logic [1:0]  status;
		logic        run_last;
	} out_item_t;

	// continuation bytes that follow a lead byte
	function automatic logic [2:0] extra_for(input logic [7:0] b);
		logic [2:0] e;
		priority if (b < 8'hC0) e = 3'd0;
		else if (b < 8'hE0) e = 3'd1;
		else if (b < 8'hF0) e = 3'd2;
		else if (b < 8'hF8) e = 3'd3;
		else if (b < 8'hFC) e = 3'd4;
		else e = 3'd5;
		return e;
	endfunction

endpackage

[src/utf8_to_utf16_transcoder_core.sv]
// UTF-8 to UTF-16 transcoder.
// Input channel: in_valid / in_stall / in_data carries one source byte per
// item, with end_of_stream set on the final byte of a stream. Output channel:
// out_valid / out_stall / out_data carries one result per item: a UTF-16 code
// unit (kind 0) or the end-of-stream status (kind 1: ok, exhausted, illegal).
// run_last marks the last result a source byte caused; a byte may cause none.
// strict_mode is written through cfg_wr_en / cfg_wr_data, and the user must
// do so only while idle; the block itself has no check for this. A result
// passes through the input register, then a three-entry result buffer, and is
// shown on out_data from entry zero. Throughput: one byte per cycle while each
// byte gives at most one result and the receiver does not stall; a byte that
// gives several results holds the result buffer until they drain (surrogate
// pair plus status gives three), and the input register waits behind it.
// Reset clears the sequence state and the buffers and sets strict_mode to 1.
// When the receiver stalls, the buffered result holds, the input register
// fills, and in_stall rises until the buffer can take the next byte's results.
// After the status result the stream state returns to zero.
module utf8_to_utf16_transcoder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  utt_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output utt_pkg::out_item_t  out_data
);
	import utt_pkg::*;

	logic        strict_q;
	logic        valid_s1;
	in_item_t    item_s1;
	logic [20:0] acc_q;
	logic [2:0]  left_q;
	logic [7:0]  lead_q;
	logic        bad_q;
	logic        halted_q;
	logic [1:0]  stat_q;
	out_item_t   res_q [MaxResults];
	logic [1:0]  cnt_q;

	logic        pop;
	logic        adv;
	logic [20:0] acc_n;
	logic [2:0]  left_n;
	logic [7:0]  lead_n;
	logic        bad_n;
	logic        done;
	logic        stop;
	logic [1:0]  nu;
	logic [15:0] unit0;
	logic [15:0] unit1;
	logic [19:0] v;
	logic [2:0]  ext;
	logic [7:0]  lo;
	logic [7:0]  hi;
	logic [1:0]  end_st;
	out_item_t   res_n [MaxResults];
	logic [1:0]  res_cnt;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b1;
		end else if (cfg_wr_en) begin
			strict_q <= cfg_wr_data;
		end
	end

	// handshakes
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = res_q[0];
	assign pop       = out_valid && !out_stall;
	assign adv       = valid_s1 && (res_cnt == 2'd0 || cnt_q == 2'd0 ||
		(cnt_q == 2'd1 && pop));
	assign in_stall  = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// sequence collection and checks
	always_comb begin
		lead_n = lead_q;
		bad_n  = bad_q;
		acc_n  = acc_q;
		left_n = left_q;
		lo     = 8'h80;
		hi     = 8'hBF;
		ext    = extra_for(item_s1.in_byte);
		if (left_q == 3'd0) begin
			lead_n = item_s1.in_byte;
			bad_n  = (item_s1.in_byte >= 8'h80 && item_s1.in_byte < 8'hC2) ||
				(item_s1.in_byte > 8'hF4);
			unique case (ext)
				3'd0:    acc_n = {14'd0, item_s1.in_byte[6:0]};
				3'd1:    acc_n = {16'd0, item_s1.in_byte[4:0]};
				3'd2:    acc_n = {17'd0, item_s1.in_byte[3:0]};
				3'd3:    acc_n = {18'd0, item_s1.in_byte[2:0]};
				default: acc_n = 21'd0;
			endcase
			left_n = ext;
			done   = (ext == 3'd0);
		end else begin
			// second-byte limits after E0, F0 and F4
			if (left_q == extra_for(lead_q)) begin
				priority if (lead_q == 8'hE0) lo = 8'hA0;
				else if (lead_q == 8'hF0) lo = 8'h90;
				else if (lead_q == 8'hF4) hi = 8'h8F;
				else lo = 8'h80;
			end
			if (item_s1.in_byte < lo || item_s1.in_byte > hi) begin
				bad_n = 1'b1;
			end
			acc_n  = {acc_q[14:0], item_s1.in_byte[5:0]};
			left_n = left_q - 3'd1;
			done   = (left_n == 3'd0);
		end
	end

	// code point to code units
	assign v = acc_n[19:0] - SuppBase[19:0];
	always_comb begin
		stop  = 1'b0;
		nu    = 2'd0;
		unit0 = 16'd0;
		unit1 = 16'd0;
		if (!halted_q && done) begin
			priority if (bad_n) begin
				stop = 1'b1;
			end else if (acc_n[20:16] == 5'd0) begin
				if (strict_q && acc_n[15:0] >= HiSurBase && acc_n[15:0] <= SurLast) begin
					stop = 1'b1;
				end else begin
					nu    = 2'd1;
					unit0 = acc_n[15:0];
				end
			end else if (acc_n > CodeMax) begin
				stop = 1'b1;
			end else begin
				nu    = 2'd2;
				unit0 = HiSurBase + {6'd0, v[19:10]};
				unit1 = LoSurBase + {6'd0, v[9:0]};
			end
		end
	end

	// end-of-stream status
	always_comb begin
		priority if (halted_q || stop) end_st = ST_ILLEGAL;
		else if (left_n != 3'd0) end_st = ST_EXHAUSTED;
		else end_st = ST_OK;
	end

	// results of this item
	always_comb begin
		out_item_t st_item;
		st_item = '{code_unit: 16'd0, kind: KIND_STATUS, status: end_st, run_last: 1'b1};
		for (int i = 0; i < MaxResults; i++) begin
			res_n[i] = '0;
		end
		unique case (nu)
			2'd1: begin
				res_n[0] = '{code_unit: unit0, kind: KIND_UNIT, status: ST_OK,
					run_last: !item_s1.end_of_stream};
			end
			2'd2: begin
				res_n[0] = '{code_unit: unit0, kind: KIND_UNIT, status: ST_OK, run_last: 1'b0};
				res_n[1] = '{code_unit: unit1, kind: KIND_UNIT, status: ST_OK,
					run_last: !item_s1.end_of_stream};
			end
			default: begin
			end
		endcase
		if (item_s1.end_of_stream) begin
			unique case (nu)
				2'd0:    res_n[0] = st_item;
				2'd1:    res_n[1] = st_item;
				default: res_n[2] = st_item;
			endcase
		end
		res_cnt = nu + {1'b0, item_s1.end_of_stream};
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= 21'd0;
			left_q   <= 3'd0;
			lead_q   <= 8'd0;
			bad_q    <= 1'b0;
			halted_q <= 1'b0;
			stat_q   <= ST_OK;
		end else if (adv) begin
			if (item_s1.end_of_stream) begin
				acc_q    <= 21'd0;
				left_q   <= 3'd0;
				lead_q   <= 8'd0;
				bad_q    <= 1'b0;
				halted_q <= 1'b0;
				stat_q   <= ST_OK;
			end else if (!halted_q) begin
				acc_q  <= acc_n;
				left_q <= left_n;
				lead_q <= lead_n;
				bad_q  <= bad_n;
				if (stop) begin
					halted_q <= 1'b1;
					stat_q   <= ST_ILLEGAL;
				end
			end
		end
	end

	// result buffer, drained from entry zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv && res_cnt != 2'd0) begin
			cnt_q <= res_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_cnt != 2'd0) begin
			for (int i = 0; i < MaxResults; i++) begin
				res_q[i] <= res_n[i];
			end
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

`ifndef SYNTHESIS
	a_status_zero_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind |-> out_data.code_unit == 16'd0)
		else $error("status result carries a nonzero code unit");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind |-> out_data.run_last)
		else $error("status result not marked last");

	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && adv && !item_s1.end_of_stream |-> res_cnt == 2'd0)
		else $error("result produced while halted");

	a_halt_status: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q == (stat_q == ST_ILLEGAL))
		else $error("halt flag and stored status disagree");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_cnt != 2'd0 |-> cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))
		else $error("result buffer overwritten before drained");
`endif

endmodule
